[src/bdlp_pkg.sv]
package bdlp_pkg;

  // Width of the millisecond time arithmetic. All differences wrap modulo 2^TimeBits.
  localparam int TimeBits = 32;

  localparam int NowBits  = 32;
  localparam int MsBits   = 16;
  localparam int CfgIdxBits = 2;
  localparam int CfgDataBits = 16;

  typedef logic [TimeBits-1:0] time_t;

  typedef enum logic [1:0] {
    MODE_UNAVAIL = 2'd0,
    MODE_REFRESH = 2'd1,
    MODE_PREV    = 2'd2,
    MODE_NEXT    = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_REFRESH = 3'd1,
    EV_PREV    = 3'd2,
    EV_NEXT    = 3'd3,
    EV_CLEAR   = 3'd4
  } event_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_MODE     = 2'd0,
    CFG_DEBOUNCE = 2'd1,
    CFG_LONG     = 2'd2,
    CFG_UNUSED   = 2'd3
  } cfg_idx_e;

  localparam logic KindStart  = 1'b0;
  localparam logic KindSample = 1'b1;

  typedef struct packed {
    logic              kind;
    logic              level;
    logic              suppress_held;
    logic [NowBits-1:0] now_time;
  } in_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic       start_ok;
  } out_t;

  typedef struct packed {
    mode_e             control_mode;
    logic [MsBits-1:0] debounce_time;
    logic [MsBits-1:0] long_press_time;
  } cfg_t;

  function automatic time_t now_to_time(logic [NowBits-1:0] v);
    time_t t;
    t = '0;
    for (int i = 0; i < TimeBits; i++) begin
      if (i < NowBits) begin
        t[i] = v[i];
      end
    end
    return t;
  endfunction

  function automatic time_t ms_to_time(logic [MsBits-1:0] v);
    time_t t;
    t = '0;
    for (int i = 0; i < TimeBits; i++) begin
      if (i < MsBits) begin
        t[i] = v[i];
      end
    end
    return t;
  endfunction

  function automatic event_e release_event(mode_e m);
    event_e ev;
    unique case (m)
      MODE_REFRESH: ev = EV_REFRESH;
      MODE_PREV:    ev = EV_PREV;
      MODE_NEXT:    ev = EV_NEXT;
      default:      ev = EV_NONE;
    endcase
    return ev;
  endfunction

endpackage

[src/bdlp_core.sv]
module bdlp_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  bdlp_pkg::in_t  item_i,
  input  bdlp_pkg::cfg_t cfg_i,
  output bdlp_pkg::out_t res_o
);
  import bdlp_pkg::*;

  logic              available_q, available_d;
  logic              raw_level_q, raw_level_d;
  time_t             raw_change_q, raw_change_d;
  logic              stable_q, stable_d;
  logic              press_active_q, press_active_d;
  logic              long_done_q, long_done_d;
  logic              suppress_q, suppress_d;
  time_t             press_time_q, press_time_d;
  mode_e             mode_q, mode_d;
  logic [MsBits-1:0] deb_q, deb_d;
  logic [MsBits-1:0] long_q, long_d;

  time_t  now;
  time_t  deb_t;
  time_t  long_t;
  time_t  accepted;
  event_e ev;
  logic   ok;
  logic   settle;

  assign now    = now_to_time(item_i.now_time);
  assign deb_t  = ms_to_time(deb_q);
  assign long_t = ms_to_time(long_q);

  always_comb begin
    available_d    = available_q;
    raw_level_d    = raw_level_q;
    raw_change_d   = raw_change_q;
    stable_d       = stable_q;
    press_active_d = press_active_q;
    long_done_d    = long_done_q;
    suppress_d     = suppress_q;
    press_time_d   = press_time_q;
    mode_d         = mode_q;
    deb_d          = deb_q;
    long_d         = long_q;
    ev             = EV_NONE;
    ok             = 1'b0;
    settle         = 1'b0;
    accepted       = '0;

    if (item_i.kind == KindStart) begin
      available_d    = 1'b0;
      raw_level_d    = 1'b0;
      raw_change_d   = '0;
      stable_d       = 1'b0;
      press_active_d = 1'b0;
      long_done_d    = 1'b0;
      suppress_d     = 1'b0;
      press_time_d   = '0;
      mode_d         = cfg_i.control_mode;
      deb_d          = cfg_i.debounce_time;
      long_d         = cfg_i.long_press_time;
      if (cfg_i.control_mode == MODE_UNAVAIL) begin
        ok = 1'b1;
      end else if (cfg_i.debounce_time == '0 ||
                   (cfg_i.control_mode == MODE_REFRESH && cfg_i.long_press_time == '0)) begin
        ok = 1'b0;
      end else begin
        ok           = 1'b1;
        available_d  = 1'b1;
        raw_level_d  = item_i.level;
        raw_change_d = now;
        stable_d     = item_i.level & item_i.suppress_held;
        suppress_d   = item_i.level & item_i.suppress_held;
      end
    end else if (available_q) begin
      raw_level_d = item_i.level;
      if (item_i.level != raw_level_q) begin
        raw_change_d = now;
      end
      settle   = (raw_level_d != stable_q) && ((now - raw_change_d) >= deb_t);
      accepted = raw_change_d + deb_t;
      if (settle) begin
        stable_d = raw_level_d;
        if (raw_level_d) begin
          press_active_d = 1'b1;
          long_done_d    = 1'b0;
          press_time_d   = accepted;
        end else if (suppress_q) begin
          // release of a press that was held at start: swallow it
          suppress_d     = 1'b0;
          press_active_d = 1'b0;
          long_done_d    = 1'b0;
        end else if (press_active_q) begin
          if (mode_q == MODE_REFRESH && !long_done_q &&
              (accepted - press_time_q) >= long_t) begin
            ev          = EV_CLEAR;
            long_done_d = 1'b1;
          end else if (!long_done_q) begin
            ev = release_event(mode_q);
          end
          press_active_d = 1'b0;
        end
      end
      if (ev == EV_NONE && stable_d && press_active_d && !suppress_d && !long_done_d &&
          mode_q == MODE_REFRESH && (now - press_time_d) >= long_t) begin
        long_done_d = 1'b1;
        ev          = EV_CLEAR;
      end
    end
  end

  assign res_o.event_res = ev;
  assign res_o.start_ok  = ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      available_q    <= 1'b0;
      raw_level_q    <= 1'b0;
      raw_change_q   <= '0;
      stable_q       <= 1'b0;
      press_active_q <= 1'b0;
      long_done_q    <= 1'b0;
      suppress_q     <= 1'b0;
      press_time_q   <= '0;
      mode_q         <= MODE_UNAVAIL;
      deb_q          <= '0;
      long_q         <= '0;
    end else if (fire_i) begin
      available_q    <= available_d;
      raw_level_q    <= raw_level_d;
      raw_change_q   <= raw_change_d;
      stable_q       <= stable_d;
      press_active_q <= press_active_d;
      long_done_q    <= long_done_d;
      suppress_q     <= suppress_d;
      press_time_q   <= press_time_d;
      mode_q         <= mode_d;
      deb_q          <= deb_d;
      long_q         <= long_d;
    end
  end

`ifndef SYNTHESIS
  a_clear_only_refresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && ev == EV_CLEAR |-> mode_q == MODE_REFRESH)
    else $error("clear event outside refresh/clear mode");

  a_no_event_unavail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !available_q |-> ev == EV_NONE)
    else $error("event while not available");

  a_suppress_needs_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    suppress_q |-> stable_q || fire_i)
    else $error("suppression set without held level");
`endif

endmodule

[src/button_debounce_long_press.sv]
// Debounced push-button with optional long press.
// Input channel (in_valid_i/in_ready_o, in_data_i): one word per sample or start
// command, each carrying the raw level and a wrapping millisecond timestamp.
// Output channel (out_valid_o/out_ready_i, out_data_o): exactly one result word
// per input word, in order: the event code and, for start words, start_ok.
// Config channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i): 0 mode,
// 1 debounce time, 2 long-press time; always ready, other indexes ignored.
// Settings are latched by a start word, so write them while the block is idle.
// Pipeline: input register, then result register. Throughput: one word per cycle
// while the receiver keeps up; the state update is a single pass of
// add/subtract/compare logic between the two registers.
// If the receiver stalls, the result register holds and one more word is taken
// into the input register; in_ready_o then drops until the output drains.
// Reset: both stages empty, config at mode 0, debounce 50, long press 1000;
// samples before the first start word give no events.
module button_debounce_long_press (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  bdlp_pkg::in_t                        in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output bdlp_pkg::out_t                       out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [bdlp_pkg::CfgIdxBits-1:0]      cfg_index_i,
  input  logic [bdlp_pkg::CfgDataBits-1:0]     cfg_data_i
);
  import bdlp_pkg::*;

  cfg_t cfg_q;
  logic s1_valid_q, s1_valid_d;
  in_t  s1_q;
  logic out_valid_q, out_valid_d;
  out_t out_q;
  out_t res;
  logic advance;
  logic in_fire;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.control_mode    <= MODE_UNAVAIL;
      cfg_q.debounce_time   <= MsBits'(50);
      cfg_q.long_press_time <= MsBits'(1000);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MODE:     cfg_q.control_mode    <= mode_e'(cfg_data_i[1:0]);
        CFG_DEBOUNCE: cfg_q.debounce_time   <= cfg_data_i[MsBits-1:0];
        CFG_LONG:     cfg_q.long_press_time <= cfg_data_i[MsBits-1:0];
        default:      ;
      endcase
    end
  end

  // the input stage moves on whenever the result register is free or being drained
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = s1_valid_q;
      s1_valid_d  = 1'b0;
    end
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= in_data_i;
    end
    if (advance && s1_valid_q) begin
      out_q <= res;
    end
  end

  bdlp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance && s1_valid_q),
    .item_i (s1_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_start_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.start_ok |-> out_data_o.event_res == EV_NONE)
    else $error("start word carries an event");

  a_event_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.event_res <= EV_CLEAR)
    else $error("event code out of range");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q && $stable(s1_q))
    else $error("input stage lost a word while stalled");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with a free stage");
`endif

endmodule

[tb/button_debounce_long_press_tb.sv]
`timescale 1ns / 1ps

module button_debounce_long_press_tb;
  import bdlp_pkg::*;

  localparam int WatchdogLimit = 5000;
  localparam int HoldCycles    = 300;
  localparam int ItemTarget    = 1100;
  localparam int ReportCap     = 100;

  // Tracks the debounce state machine and holds the result words still owed by the block.
  class debounce_scoreboard;
    mode_e             reg_mode;
    logic [MsBits-1:0] reg_deb;
    logic [MsBits-1:0] reg_long;
    mode_e             armed_mode;
    logic [MsBits-1:0] armed_deb;
    logic [MsBits-1:0] armed_long;
    bit                available;
    bit                raw_level;
    bit                stable_level;
    bit                press_active;
    bit                long_done;
    bit                suppress;
    time_t             raw_change;
    time_t             press_start;
    out_t              expected_results[$];
    int                mismatches;
    int                checked;

    function new();
      reg_mode   = MODE_UNAVAIL;
      reg_deb    = MsBits'(50);
      reg_long   = MsBits'(1000);
      mismatches = 0;
      checked    = 0;
      clear_state();
    endfunction

    function void clear_state();
      available    = 1'b0;
      raw_level    = 1'b0;
      stable_level = 1'b0;
      press_active = 1'b0;
      long_done    = 1'b0;
      suppress     = 1'b0;
      raw_change   = '0;
      press_start  = '0;
      armed_mode   = MODE_UNAVAIL;
      armed_deb    = '0;
      armed_long   = '0;
    endfunction

    function void note_register(cfg_idx_e idx, logic [CfgDataBits-1:0] d);
      case (idx)
        CFG_MODE:     reg_mode = mode_e'(d[1:0]);
        CFG_DEBOUNCE: reg_deb = d[MsBits-1:0];
        CFG_LONG:     reg_long = d[MsBits-1:0];
        default:      ;
      endcase
    endfunction

    function void note_word(in_t w);
      out_t   r;
      event_e ev;
      time_t  now;
      time_t  since;
      time_t  accepted;
      time_t  held;
      r   = '0;
      ev  = EV_NONE;
      now = w.now_time;
      if (w.kind == KindStart) begin
        clear_state();
        armed_mode = reg_mode;
        armed_deb  = reg_deb;
        armed_long = reg_long;
        if (armed_mode == MODE_UNAVAIL) begin
          r.start_ok = 1'b1;
        end else if (armed_deb == 0 || (armed_mode == MODE_REFRESH && armed_long == 0)) begin
          r.start_ok = 1'b0;
        end else begin
          available  = 1'b1;
          raw_level  = w.level;
          raw_change = now;
          // button already down at start: hold it off until released
          if (w.level && w.suppress_held) begin
            stable_level = 1'b1;
            suppress     = 1'b1;
          end
          r.start_ok = 1'b1;
        end
      end else if (available) begin
        if (w.level != raw_level) begin
          raw_level  = w.level;
          raw_change = now;
        end
        since = now - raw_change;
        if (raw_level != stable_level && since >= time_t'(armed_deb)) begin
          accepted     = raw_change + time_t'(armed_deb);
          stable_level = raw_level;
          if (stable_level) begin
            press_active = 1'b1;
            long_done    = 1'b0;
            press_start  = accepted;
          end else if (suppress) begin
            suppress     = 1'b0;
            press_active = 1'b0;
            long_done    = 1'b0;
          end else if (press_active) begin
            held = accepted - press_start;
            if (armed_mode == MODE_REFRESH && !long_done && held >= time_t'(armed_long)) begin
              ev        = EV_CLEAR;
              long_done = 1'b1;
            end else if (!long_done) begin
              case (armed_mode)
                MODE_REFRESH: ev = EV_REFRESH;
                MODE_PREV:    ev = EV_PREV;
                MODE_NEXT:    ev = EV_NEXT;
                default:      ev = EV_NONE;
              endcase
            end
            press_active = 1'b0;
          end
        end
        held = now - press_start;
        if (ev == EV_NONE && stable_level && press_active && !suppress && !long_done &&
            armed_mode == MODE_REFRESH && held >= time_t'(armed_long)) begin
          long_done = 1'b1;
          ev        = EV_CLEAR;
        end
      end
      r.event_res = ev;
      expected_results.push_back(r);
    endfunction

    function void check_word(out_t got);
      out_t exp_w;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportCap)
          $error("event_res: no result word expected, got %0d (start_ok %0d)",
                 got.event_res, got.start_ok);
        return;
      end
      exp_w = expected_results.pop_front();
      checked++;
      if (got.event_res !== exp_w.event_res) begin
        mismatches++;
        if (mismatches <= ReportCap)
          $error("event_res: expected %0d, actual %0d", exp_w.event_res, got.event_res);
      end
      if (got.start_ok !== exp_w.start_ok) begin
        mismatches++;
        if (mismatches <= ReportCap)
          $error("start_ok: expected %0d, actual %0d", exp_w.start_ok, got.start_ok);
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void report_leftover();
      if (expected_results.size() != 0) begin
        mismatches++;
        $error("event_res: %0d expected result words never arrived", expected_results.size());
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready_o;
  in_t                    in_data = '0;
  logic                   out_valid_o;
  logic                   out_ready = 1'b0;
  out_t                   out_data_o;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready_o;
  cfg_idx_e               cfg_index = CFG_MODE;
  logic [CfgDataBits-1:0] cfg_data = '0;

  debounce_scoreboard sb = new();

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_req = 1'b0;
  int          stall_cycles = 0;
  int          words_sent = 0;
  int          starts_sent = 0;
  int          settings_used = 0;
  int unsigned set_deb = 50;
  int unsigned set_long = 1000;

  always #4 clk = ~clk;

  button_debounce_long_press dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // handshakes are sampled with pre-edge values
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready_o) sb.note_word(in_data);
      if (out_valid_o && out_ready) sb.check_word(out_data_o);
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || (cfg_valid && cfg_ready_o))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WatchdogLimit) begin
        $display("Watchdog: no handshake for %0d cycles", stall_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // result receiver; a hold request parks it for a long stretch so the block backs up
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send(input logic k, input logic l, input logic s, input logic [31:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{kind: k, level: l, suppress_held: s, now_time: t};
    do @(posedge clk); while (!in_ready_o);
    words_sent++;
    if (k == KindStart) starts_sent++;
  endtask

  // step past the current edge first so the word accepted there is already counted
  task automatic wait_idle();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataBits-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready_o);
    sb.note_register(idx, d);
  endtask

  // settings are only touched once the block has drained
  task automatic set_config(input mode_e m, input int unsigned deb, input int unsigned lng);
    logic [CfgDataBits-1:0] junk;
    in_valid <= 1'b0;
    wait_idle();
    junk = CfgDataBits'($urandom);
    write_reg(CFG_MODE, {junk[CfgDataBits-1:2], m});
    write_reg(CFG_DEBOUNCE, deb[CfgDataBits-1:0]);
    write_reg(CFG_LONG, lng[CfgDataBits-1:0]);
    write_reg(CFG_UNUSED, CfgDataBits'($urandom));
    cfg_valid <= 1'b0;
    set_deb = deb;
    set_long = lng;
    settings_used++;
  endtask

  task automatic random_settings();
    mode_e       m;
    int unsigned deb;
    int unsigned lng;
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) m = MODE_UNAVAIL;
    else if (pick <= 5) m = MODE_REFRESH;
    else if (pick <= 7) m = MODE_PREV;
    else m = MODE_NEXT;
    case ($urandom_range(19))
      0:       deb = 0;
      1:       deb = 1;
      2:       deb = 65535;
      3:       deb = $urandom_range(65535);
      default: deb = $urandom_range(1, 30);
    endcase
    case ($urandom_range(19))
      0:       lng = 0;
      1:       lng = 1;
      2:       lng = 65535;
      3:       lng = $urandom_range(65535);
      default: begin
        lng = deb + $urandom_range(1, 200);
        if (lng > 65535) lng = 65535;
      end
    endcase
    set_config(m, deb, lng);
  endtask

  // a start followed by presses, bounces and holds scaled to the current times
  task automatic run_session(input int n);
    logic [31:0] now;
    logic        lvl;
    int unsigned step;
    int unsigned pick;
    now = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(300) : $urandom;
    lvl = 1'($urandom_range(1));
    send(KindStart, lvl, 1'($urandom_range(1)), now);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        send(KindSample, 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom);
      end else if (pick < 7) begin
        now += $urandom_range(50);
        lvl = 1'($urandom_range(1));
        send(KindStart, lvl, 1'($urandom_range(1)), now);
      end else begin
        case ($urandom_range(7))
          0:       step = 0;
          1:       step = $urandom_range(set_deb);
          2:       step = set_deb + $urandom_range(2);
          3:       step = set_long + $urandom_range(2);
          4:       step = $urandom_range(set_long);
          5:       step = $urandom;
          default: step = $urandom_range(1, 2 * set_deb + 1);
        endcase
        now += step;
        if ($urandom_range(99) < 35) lvl = ~lvl;
        send(KindSample, lvl, 1'($urandom_range(1)), now);
      end
    end
  endtask

  initial begin
    int session;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 25;
    recv_idle_pct = 77;

    // sample ahead of any start, then start in unavailable mode
    send(KindSample, 1'b1, 1'b1, 32'hFFFF_FFFF);
    send(KindStart, 1'b0, 1'b0, 32'h0);
    // zero debounce and zero long-press both refuse the start
    set_config(MODE_REFRESH, 0, 1000);
    send(KindStart, 1'b1, 1'b0, 32'h5);
    send(KindSample, 1'b1, 1'b0, 32'h9);
    set_config(MODE_REFRESH, 1, 0);
    send(KindStart, 1'b0, 1'b0, 32'h0);
    // zero long-press is fine outside refresh mode
    set_config(MODE_PREV, 1, 0);
    send(KindStart, 1'b0, 1'b0, 32'd10);
    send(KindSample, 1'b1, 1'b0, 32'd11);
    send(KindSample, 1'b1, 1'b0, 32'd12);
    send(KindSample, 1'b0, 1'b0, 32'd13);
    send(KindSample, 1'b0, 1'b0, 32'd14);
    // bounce, long press across the time wrap, then a short press
    set_config(MODE_REFRESH, 5, 20);
    send(KindStart, 1'b0, 1'b0, 32'hFFFF_FFF0);
    send(KindSample, 1'b1, 1'b0, 32'hFFFF_FFF4);
    send(KindSample, 1'b0, 1'b0, 32'hFFFF_FFF6);
    send(KindSample, 1'b1, 1'b0, 32'hFFFF_FFF7);
    send(KindSample, 1'b1, 1'b0, 32'hFFFF_FFFC);
    send(KindSample, 1'b1, 1'b0, 32'h10);
    send(KindSample, 1'b0, 1'b0, 32'h11);
    send(KindSample, 1'b0, 1'b0, 32'h16);
    send(KindSample, 1'b1, 1'b0, 32'h20);
    send(KindSample, 1'b1, 1'b0, 32'h25);
    send(KindSample, 1'b0, 1'b0, 32'h27);
    send(KindSample, 1'b0, 1'b0, 32'h2C);
    // held at start with suppression, widest times
    set_config(MODE_NEXT, 65535, 65535);
    send(KindStart, 1'b1, 1'b1, 32'h0);
    send(KindSample, 1'b0, 1'b0, 32'h1);
    send(KindSample, 1'b0, 1'b0, 32'h1_0000);

    session = 0;
    while (words_sent < ItemTarget) begin
      if (words_sent > 2 * ItemTarget / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (words_sent > ItemTarget / 3) begin
        send_idle_pct = 77;
        recv_idle_pct = 25;
      end
      random_settings();
      if (session == 6) hold_req = 1'b1;
      run_session($urandom_range(10, 40));
      session++;
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    sb.report_leftover();

    $display("Drove %0d words (%0d starts) over %0d register settings,",
             words_sent, starts_sent, settings_used);
    $display("mixed idling and a %0d-cycle output stall; compared %0d result words.",
             HoldCycles, sb.checked);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
